// File: rtl/core/hds_pkg.sv
package hds_pkg;

  // grid limits
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 11;

  // datapath widths
  localparam int VAL_W     = 32;
  localparam int WGT_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = VAL_W + 3;
  localparam int PROD_W    = DIFF_W + WGT_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int STEP_W    = SUM_W - FRAC_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_Y  = 2'd3;

  // constants
  localparam logic [SIZE_W-1:0]        MIN_SIZE     = SIZE_W'(3);
  localparam logic [SIZE_W-1:0]        RESET_SIZE   = SIZE_W'(11);
  localparam logic [WGT_W-1:0]         RESET_WEIGHT = WGT_W'(1000);
  localparam logic [WGT_W:0]           HALF_WEIGHT  = (WGT_W + 1)'(32768);
  localparam logic signed [SUM_W-1:0]  ROUND_HALF   = SUM_W'(32768);

  typedef logic [COL_W-1:0]        col_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // column control from the sequencer to the line stores
  typedef struct packed {
    logic wr_en;
    col_t col;
    col_t col_nxt;
    logic bank;
    logic bank_nxt;
    logic row_end;
  } line_ctl_t;

  // neighbors of the cell in the row above the incoming one
  typedef struct packed {
    val_t left;
    val_t ctr;
    val_t right;
    val_t up;
  } taps_t;

  // operands of one request
  typedef struct packed {
    val_t left;
    val_t ctr;
    val_t right;
    val_t up;
    val_t down;
    logic inner;
    logic emit_a;
    logic emit_b;
    logic last;
    logic unst;
  } stencil_t;

  // weighted sum stage
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    val_t ctr;
    val_t down;
    logic use_calc;
    logic emit_a;
    logic emit_b;
    logic last;
    logic unst;
  } sum_t;

  // finished results of one request
  typedef struct packed {
    val_t             new_a;
    logic [VAL_W-1:0] chg_a;
    val_t             down;
    logic             emit_a;
    logic             emit_b;
    logic             last;
    logic             unst;
  } result_t;

  // grid size clamped into [3, hi]
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < MIN_SIZE) r = MIN_SIZE;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// File: rtl/core/hds_line_ram.sv
module hds_line_ram (
  input  logic          clk,
  input  logic          wr_en,
  input  hds_pkg::col_t wr_addr,
  input  hds_pkg::val_t wr_data,
  input  hds_pkg::col_t rd_addr,
  output hds_pkg::val_t rd_data
);

  hds_pkg::val_t mem [hds_pkg::MAX_COLS];
  hds_pkg::val_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, returns the new data on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/hds_line_buf.sv
module hds_line_buf (
  input  logic               clk,
  input  hds_pkg::line_ctl_t ctl,
  input  hds_pkg::val_t      cell_value,
  output hds_pkg::taps_t     taps
);

  hds_pkg::col_t far_addr;
  hds_pkg::col_t ram0_rd_addr;
  hds_pkg::col_t ram1_rd_addr;
  hds_pkg::val_t ram0_rd;
  hds_pkg::val_t ram1_rd;
  hds_pkg::val_t far_data;
  logic          ram0_we;
  logic          ram1_we;
  hds_pkg::val_t left_r;
  hds_pkg::val_t ctr_r;
  hds_pkg::val_t right_r;
  hds_pkg::val_t head0_r;
  hds_pkg::val_t head1_r;

  // newer row is prefetched two columns ahead, older row at the next column
  assign far_addr     = ctl.col_nxt + hds_pkg::col_t'(2);
  assign ram0_rd_addr = ctl.bank_nxt ? ctl.col_nxt : far_addr;
  assign ram1_rd_addr = ctl.bank_nxt ? far_addr : ctl.col_nxt;

  // incoming cell overwrites the older row
  assign ram0_we = ctl.wr_en & ctl.bank;
  assign ram1_we = ctl.wr_en & ~ctl.bank;

  hds_line_ram u_ram0 (
    .clk     (clk),
    .wr_en   (ram0_we),
    .wr_addr (ctl.col),
    .wr_data (cell_value),
    .rd_addr (ram0_rd_addr),
    .rd_data (ram0_rd)
  );

  hds_line_ram u_ram1 (
    .clk     (clk),
    .wr_en   (ram1_we),
    .wr_addr (ctl.col),
    .wr_data (cell_value),
    .rd_addr (ram1_rd_addr),
    .rd_data (ram1_rd)
  );

  assign far_data = ctl.bank ? ram1_rd : ram0_rd;

  // three-tap window over the newer row, reloaded from the row head at row end
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      if (ctl.col == '0) begin
        head0_r <= cell_value;
      end
      if (ctl.col == hds_pkg::col_t'(1)) begin
        head1_r <= cell_value;
      end
      left_r <= ctr_r;
      if (ctl.row_end) begin
        ctr_r   <= head0_r;
        right_r <= head1_r;
      end else begin
        ctr_r   <= right_r;
        right_r <= far_data;
      end
    end
  end

  assign taps.left  = left_r;
  assign taps.ctr   = ctr_r;
  assign taps.right = right_r;
  assign taps.up    = ctl.bank ? ram0_rd : ram1_rd;

endmodule

// File: rtl/core/hds_calc.sv
module hds_calc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s_valid,
  output logic                            s_ready,
  input  hds_pkg::stencil_t               s_data,
  input  logic [hds_pkg::WGT_W-1:0]       weight_x,
  input  logic [hds_pkg::WGT_W-1:0]       weight_y,
  output logic                            m_valid,
  output hds_pkg::result_t                m_data,
  input  logic                            m_pop
);

  hds_pkg::stencil_t p_r;
  hds_pkg::sum_t     q_r;
  hds_pkg::result_t  m_r;
  logic              p_valid_r;
  logic              q_valid_r;
  logic              m_valid_r;
  logic              m_free;
  logic              q_free;
  logic              p_free;

  logic signed [hds_pkg::DIFF_W-1:0] dv;
  logic signed [hds_pkg::DIFF_W-1:0] dh;
  logic signed [hds_pkg::WGT_W:0]    wx_s;
  logic signed [hds_pkg::WGT_W:0]    wy_s;
  logic signed [hds_pkg::PROD_W-1:0] prod_x;
  logic signed [hds_pkg::PROD_W-1:0] prod_y;
  hds_pkg::sum_t                     q_nxt;

  logic signed [hds_pkg::SUM_W-1:0]  rnd;
  logic signed [hds_pkg::STEP_W-1:0] step;
  logic signed [hds_pkg::STEP_W:0]   tot;
  hds_pkg::val_t                     sat_v;
  hds_pkg::val_t                     new_a;
  logic signed [hds_pkg::VAL_W:0]    diff;
  logic signed [hds_pkg::VAL_W:0]    diff_neg;
  hds_pkg::result_t                  m_nxt;

  // stall chain
  assign m_free  = !m_valid_r || m_pop;
  assign q_free  = !q_valid_r || m_free;
  assign p_free  = !p_valid_r || q_free;
  assign s_ready = p_free;

  // second differences and weighted sum at Q21.32
  always_comb begin
    dv = hds_pkg::DIFF_W'(p_r.up) + hds_pkg::DIFF_W'(p_r.down)
       - (hds_pkg::DIFF_W'(p_r.ctr) <<< 1);
    dh = hds_pkg::DIFF_W'(p_r.left) + hds_pkg::DIFF_W'(p_r.right)
       - (hds_pkg::DIFF_W'(p_r.ctr) <<< 1);
    wx_s   = $signed({1'b0, weight_x});
    wy_s   = $signed({1'b0, weight_y});
    prod_x = hds_pkg::PROD_W'(dv) * hds_pkg::PROD_W'(wx_s);
    prod_y = hds_pkg::PROD_W'(dh) * hds_pkg::PROD_W'(wy_s);
    q_nxt.sum      = hds_pkg::SUM_W'(prod_x) + hds_pkg::SUM_W'(prod_y);
    q_nxt.ctr      = p_r.ctr;
    q_nxt.down     = p_r.down;
    q_nxt.use_calc = p_r.inner && !p_r.unst;
    q_nxt.emit_a   = p_r.emit_a;
    q_nxt.emit_b   = p_r.emit_b;
    q_nxt.last     = p_r.last;
    q_nxt.unst     = p_r.unst;
  end

  // round to Q16.16, add, saturate, absolute change
  always_comb begin
    rnd  = q_r.sum + hds_pkg::ROUND_HALF;
    step = $signed(rnd[hds_pkg::SUM_W-1:hds_pkg::FRAC_W]);
    tot  = (hds_pkg::STEP_W + 1)'(q_r.ctr) + (hds_pkg::STEP_W + 1)'(step);
    if (tot[hds_pkg::STEP_W:hds_pkg::VAL_W-1] == '0 ||
        tot[hds_pkg::STEP_W:hds_pkg::VAL_W-1] == '1) begin
      sat_v = tot[hds_pkg::VAL_W-1:0];
    end else if (tot[hds_pkg::STEP_W]) begin
      sat_v = {1'b1, {(hds_pkg::VAL_W - 1){1'b0}}};
    end else begin
      sat_v = {1'b0, {(hds_pkg::VAL_W - 1){1'b1}}};
    end
    new_a    = q_r.use_calc ? sat_v : q_r.ctr;
    diff     = (hds_pkg::VAL_W + 1)'(new_a) - (hds_pkg::VAL_W + 1)'(q_r.ctr);
    diff_neg = -diff;
    m_nxt.new_a  = new_a;
    m_nxt.chg_a  = diff[hds_pkg::VAL_W] ? diff_neg[hds_pkg::VAL_W-1:0]
                                        : diff[hds_pkg::VAL_W-1:0];
    m_nxt.down   = q_r.down;
    m_nxt.emit_a = q_r.emit_a;
    m_nxt.emit_b = q_r.emit_b;
    m_nxt.last   = q_r.last;
    m_nxt.unst   = q_r.unst;
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
    end else begin
      if (p_free) p_valid_r <= s_valid;
      if (q_free) q_valid_r <= p_valid_r;
      if (m_free) m_valid_r <= q_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (p_free) p_r <= s_data;
    if (q_free) q_r <= q_nxt;
    if (m_free) m_r <= m_nxt;
  end

  assign m_valid = m_valid_r;
  assign m_data  = m_r;

endmodule

// File: rtl/core/heat_diffusion_stencil_step.sv
// channel   | direction | handshake           | payload
// in_       | input     | in_valid/in_ready   | in_cell_value
// out_      | output    | out_valid/out_ready | out_new_value, out_max_change,
//           |           |                     | out_frame_last, out_unstable
// cfg_      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one cell per cycle unless out_ready stalls the pipeline; a last-row cell yields two
// results and holds the input while the single output register sends both
// a result passes through the operand, sum, rounding and output registers
// synchronous active-low reset clears the counters, valids and running max and loads
// the configuration defaults; line stores hold whatever they last got
// out_ready low stalls every stage back to in_ready; cfg_ready is always high
module heat_diffusion_stencil_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [hds_pkg::VAL_W-1:0]  in_cell_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [hds_pkg::VAL_W-1:0]  out_new_value,
  output logic [hds_pkg::VAL_W-1:0]         out_max_change,
  output logic                              out_frame_last,
  output logic                              out_unstable,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hds_pkg::WGT_W-1:0]         cfg_data
);

  logic [hds_pkg::SIZE_W-1:0] grid_rows_r;
  logic [hds_pkg::SIZE_W-1:0] grid_cols_r;
  logic [hds_pkg::WGT_W-1:0]  weight_x_r;
  logic [hds_pkg::WGT_W-1:0]  weight_y_r;

  hds_pkg::col_t col_r;
  hds_pkg::col_t col_nxt;
  hds_pkg::row_t row_r;
  hds_pkg::row_t row_nxt;
  logic          bank_r;
  logic          bank_nxt;

  logic [hds_pkg::SIZE_W-1:0] rows_eff;
  logic [hds_pkg::SIZE_W-1:0] cols_eff;
  logic [hds_pkg::SIZE_W-1:0] rows_last;
  logic [hds_pkg::SIZE_W-1:0] cols_last;
  hds_pkg::row_t              last_row_idx;
  hds_pkg::col_t              last_col_idx;
  logic [hds_pkg::WGT_W:0]    weight_sum;
  logic                       row_end;
  logic                       last_row;
  logic                       unst;
  logic                       accept;

  hds_pkg::line_ctl_t line_ctl;
  hds_pkg::taps_t     taps;
  hds_pkg::stencil_t  s_data;
  logic               s_valid;
  logic               s_ready;
  logic               m_valid;
  hds_pkg::result_t   m_data;
  logic               m_pop;

  logic                        out_valid_r;
  hds_pkg::val_t               out_new_value_r;
  logic [hds_pkg::VAL_W-1:0]   out_max_change_r;
  logic                        out_frame_last_r;
  logic                        out_unstable_r;
  logic [hds_pkg::VAL_W-1:0]   max_r;
  logic                        a_done_r;
  logic                        out_load;
  logic                        emit;
  logic                        sel_a;
  logic [hds_pkg::VAL_W-1:0]   chg_sel;
  logic [hds_pkg::VAL_W-1:0]   max_new;
  logic                        frame_end;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= hds_pkg::RESET_SIZE;
      grid_cols_r <= hds_pkg::RESET_SIZE;
      weight_x_r  <= hds_pkg::RESET_WEIGHT;
      weight_y_r  <= hds_pkg::RESET_WEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hds_pkg::REG_GRID_ROWS: grid_rows_r <= cfg_data[hds_pkg::SIZE_W-1:0];
        hds_pkg::REG_GRID_COLS: grid_cols_r <= cfg_data[hds_pkg::SIZE_W-1:0];
        hds_pkg::REG_WEIGHT_X:  weight_x_r  <= cfg_data;
        hds_pkg::REG_WEIGHT_Y:  weight_y_r  <= cfg_data;
      endcase
    end
  end

  // grid position and boundary decode
  always_comb begin
    rows_eff     = hds_pkg::clamp_size(grid_rows_r, hds_pkg::SIZE_W'(hds_pkg::MAX_ROWS));
    cols_eff     = hds_pkg::clamp_size(grid_cols_r, hds_pkg::SIZE_W'(hds_pkg::MAX_COLS));
    rows_last    = rows_eff - hds_pkg::SIZE_W'(1);
    cols_last    = cols_eff - hds_pkg::SIZE_W'(1);
    last_row_idx = rows_last[hds_pkg::ROW_W-1:0];
    last_col_idx = cols_last[hds_pkg::COL_W-1:0];
    row_end      = col_r >= last_col_idx;
    last_row     = row_r >= last_row_idx;
    weight_sum   = {1'b0, weight_x_r} + {1'b0, weight_y_r};
    unst         = weight_sum > hds_pkg::HALF_WEIGHT;
  end

  assign in_ready = s_ready;
  assign accept   = in_valid && in_ready;

  // raster counters and line store bank
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (row_end) begin
        col_nxt  = '0;
        bank_nxt = ~bank_r;
        row_nxt  = last_row ? '0 : row_r + hds_pkg::row_t'(1);
      end else begin
        col_nxt = col_r + hds_pkg::col_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bank_r <= bank_nxt;
    end
  end

  assign line_ctl.wr_en    = accept;
  assign line_ctl.col      = col_r;
  assign line_ctl.col_nxt  = col_nxt;
  assign line_ctl.bank     = bank_r;
  assign line_ctl.bank_nxt = bank_nxt;
  assign line_ctl.row_end  = row_end;

  hds_line_buf u_line_buf (
    .clk        (clk),
    .ctl        (line_ctl),
    .cell_value (in_cell_value),
    .taps       (taps)
  );

  // operands for the cell above, plus the incoming cell on the last row
  always_comb begin
    s_data.left   = taps.left;
    s_data.ctr    = taps.ctr;
    s_data.right  = taps.right;
    s_data.up     = taps.up;
    s_data.down   = in_cell_value;
    s_data.inner  = (row_r >= hds_pkg::row_t'(2)) && (row_r <= last_row_idx) &&
                    (col_r != '0) && (col_r < last_col_idx);
    s_data.emit_a = row_r != '0;
    s_data.emit_b = last_row;
    s_data.last   = row_end && last_row;
    s_data.unst   = unst;
    s_valid       = in_valid && (s_data.emit_a || s_data.emit_b);
  end

  hds_calc u_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_data   (s_data),
    .weight_x (weight_x_r),
    .weight_y (weight_y_r),
    .m_valid  (m_valid),
    .m_data   (m_data),
    .m_pop    (m_pop)
  );

  // result sequencing: cell above first, then the last-row cell
  always_comb begin
    out_load  = !out_valid_r || out_ready;
    emit      = m_valid && out_load;
    sel_a     = m_data.emit_a && !a_done_r;
    m_pop     = emit && (!sel_a || !m_data.emit_b);
    chg_sel   = sel_a ? m_data.chg_a : '0;
    max_new   = (chg_sel > max_r) ? chg_sel : max_r;
    frame_end = emit && !sel_a && m_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      a_done_r    <= 1'b0;
      max_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= m_valid;
      end
      if (emit) begin
        a_done_r <= sel_a && m_data.emit_b;
        max_r    <= frame_end ? '0 : max_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_new_value_r  <= sel_a ? m_data.new_a : m_data.down;
      out_max_change_r <= max_new;
      out_frame_last_r <= !sel_a && m_data.last;
      out_unstable_r   <= m_data.unst;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_value  = out_new_value_r;
  assign out_max_change = out_max_change_r;
  assign out_frame_last = out_frame_last_r;
  assign out_unstable   = out_unstable_r;

endmodule

// File: rtl/core/hds_chk.sv
module hds_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [hds_pkg::VAL_W-1:0]  out_new_value,
  input logic [hds_pkg::VAL_W-1:0]         out_max_change,
  input logic                              out_frame_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_value) &&
                                $stable(out_max_change))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // running max only grows inside a frame
  a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_frame_last) ##1 out_valid |->
      out_max_change >= $past(out_max_change))
    else $error("max change dropped inside a frame");

  // a frame has at least nine cells, so two frame ends never follow each other
  a_frame_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_last |=> !(out_valid && out_frame_last))
    else $error("frame end repeated");

endmodule

bind heat_diffusion_stencil_step hds_chk u_hds_chk (.*);
